// ===== src/gwm_pkg.sv =====
// Shared types, constants and helpers for the glob wildcard matcher.
// Used by gwm_loader, gwm_nfa and glob_wildcard_matcher; no dependencies.
package gwm_pkg;

  // Token store geometry
  localparam int MAX_TOKENS = 32;
  localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
  localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int SET_W      = MAX_TOKENS + 1;

  // Special pattern bytes
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Token kinds
  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_ONE = 2'd1,
    KIND_RUN = 2'd2
  } kind_t;

  // One input transaction
  typedef struct packed {
    logic       func;
    logic [7:0] char_byte;
    logic       byte_valid;
    logic       last;
  } item_t;

  // Pattern status handed from the loader to the matcher
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             overflow;
  } pat_status_t;

  typedef logic [MAX_TOKENS-1:0][7:0] tok_char_vec_t;
  typedef kind_t [MAX_TOKENS-1:0]     tok_kind_vec_t;

  // Fold ASCII upper case to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== src/gwm_loader.sv =====
// Pattern compiler: turns pattern bytes into star / question / literal tokens.
// Depends on gwm_pkg. Holds the token store and pattern status registers.
module gwm_loader
  import gwm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          upd,
  input  item_t         item,
  output tok_char_vec_t token_char,
  output tok_kind_vec_t token_kind,
  output pat_status_t   status
);

  logic [CNT_W-1:0] token_count;
  logic             escape_pending;
  logic             load_overflow;
  logic             last_run;
  logic             pattern_open;

  logic [CNT_W-1:0] token_count_next;
  logic             escape_pending_next;
  logic             load_overflow_next;
  logic             last_run_next;
  logic             pattern_open_next;
  tok_char_vec_t    token_char_next;
  tok_kind_vec_t    token_kind_next;

  logic [2:0]       slot_en;
  kind_t            slot_kind [3];
  logic [7:0]       slot_ch   [3];

  logic [CNT_W-1:0] cnt0;
  logic             ovf0;
  logic             lr0;
  logic             esc0;
  logic             esc1;
  logic             c_special;

  assign status.count    = token_count;
  assign status.overflow = load_overflow;

  // Decode up to three token adds: pending backslash, the byte, close backslash
  always_comb begin
    c_special = (item.char_byte == CH_STAR) || (item.char_byte == CH_QUESTION);
    slot_en   = '0;
    slot_kind[0] = KIND_LIT;
    slot_kind[1] = KIND_LIT;
    slot_kind[2] = KIND_LIT;
    slot_ch[0]   = c_special ? item.char_byte : CH_BACKSLASH;
    slot_ch[1]   = item.char_byte;
    slot_ch[2]   = CH_BACKSLASH;
    if (item.char_byte == CH_STAR) begin
      slot_kind[1] = KIND_RUN;
    end else if (item.char_byte == CH_QUESTION) begin
      slot_kind[1] = KIND_ONE;
    end

    if (!item.func) begin
      // Pattern transaction: a new pattern starts from a cleared store
      cnt0 = pattern_open ? token_count    : '0;
      ovf0 = pattern_open ? load_overflow  : 1'b0;
      lr0  = pattern_open ? last_run       : 1'b0;
      esc0 = pattern_open ? escape_pending : 1'b0;
      slot_en[0] = item.byte_valid && esc0;
      slot_en[1] = item.byte_valid && !(esc0 && c_special) &&
                   (item.char_byte != CH_BACKSLASH);
      esc1       = item.byte_valid ? (item.char_byte == CH_BACKSLASH) : esc0;
      slot_en[2] = item.last && esc1;
      escape_pending_next = item.last ? 1'b0 : esc1;
      pattern_open_next   = !item.last;
    end else begin
      // Name transaction: close an open pattern first
      cnt0 = token_count;
      ovf0 = load_overflow;
      lr0  = last_run;
      esc0 = escape_pending;
      esc1 = escape_pending;
      slot_en[2] = pattern_open && escape_pending;
      escape_pending_next = pattern_open ? 1'b0 : escape_pending;
      pattern_open_next   = 1'b0;
    end
  end

  // Apply the adds in order: merge stars, drop on full store
  always_comb begin
    token_count_next   = cnt0;
    load_overflow_next = ovf0;
    last_run_next      = lr0;
    token_char_next    = token_char;
    token_kind_next    = token_kind;
    for (int s = 0; s < 3; s++) begin
      if (slot_en[s]) begin
        if (slot_kind[s] == KIND_RUN && last_run_next) begin
          // consecutive stars merge
        end else if (token_count_next >= CNT_W'(MAX_TOKENS)) begin
          load_overflow_next = 1'b1;
        end else begin
          token_char_next[token_count_next[IDX_W-1:0]] = fold(slot_ch[s]);
          token_kind_next[token_count_next[IDX_W-1:0]] = slot_kind[s];
          token_count_next = token_count_next + 1'b1;
          last_run_next    = (slot_kind[s] == KIND_RUN);
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      token_count    <= '0;
      escape_pending <= 1'b0;
      load_overflow  <= 1'b0;
      last_run       <= 1'b0;
      pattern_open   <= 1'b0;
    end else if (upd) begin
      token_count    <= token_count_next;
      escape_pending <= escape_pending_next;
      load_overflow  <= load_overflow_next;
      last_run       <= last_run_next;
      pattern_open   <= pattern_open_next;
    end
  end

  // Token store, folded characters
  always_ff @(posedge clk) begin
    if (upd) begin
      token_char <= token_char_next;
      token_kind <= token_kind_next;
    end
  end

endmodule

// ===== src/gwm_nfa.sv =====
// Bit-parallel active-position tracker for name bytes against the token store.
// Depends on gwm_pkg. Holds the active set and the name-in-progress flag.
module gwm_nfa
  import gwm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          upd,
  input  item_t         item,
  input  tok_char_vec_t token_char,
  input  tok_kind_vec_t token_kind,
  input  pat_status_t   status,
  output logic          res_matched,
  output logic          res_overflow
);

  logic [SET_W-1:0]      active_positions;
  logic                  in_name;

  logic [MAX_TOKENS-1:0] vmask;
  logic [MAX_TOKENS-1:0] run_mask;
  logic [SET_W-1:0]      start;
  logic [SET_W-1:0]      step;
  logic [SET_W-1:0]      closed;
  logic [SET_W-1:0]      after;
  logic [7:0]            fc;

  // Advance the set by one byte, then carry positions across stars
  always_comb begin
    fc = fold(item.char_byte);
    for (int i = 0; i < MAX_TOKENS; i++) begin
      vmask[i]    = CNT_W'(i) < status.count;
      run_mask[i] = vmask[i] && (token_kind[i] == KIND_RUN);
    end
    start = active_positions;
    if (!in_name) begin
      start    = '0;
      start[0] = 1'b1;
      start[1] = run_mask[0];
    end
    step = '0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (start[i] && vmask[i]) begin
        if (token_kind[i] == KIND_RUN) begin
          step[i] = 1'b1;
        end else if (token_kind[i] == KIND_ONE || token_char[i] == fc) begin
          step[i+1] = 1'b1;
        end
      end
    end
    closed       = step | {step[MAX_TOKENS-1:0] & run_mask, 1'b0};
    after        = item.byte_valid ? closed : start;
    res_overflow = status.overflow;
    res_matched  = after[status.count] && !status.overflow;
  end

  // Hold the set between bytes; drop it on name end or pattern transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      active_positions <= '0;
      in_name          <= 1'b0;
    end else if (upd) begin
      if (!item.func || item.last) begin
        active_positions <= '0;
        in_name          <= 1'b0;
      end else begin
        active_positions <= after;
        in_name          <= 1'b1;
      end
    end
  end

endmodule

// ===== src/glob_wildcard_matcher.sv =====
// Top level of the glob wildcard matcher: input, compile and match stages.
// Depends on gwm_pkg, gwm_loader and gwm_nfa.
//
// Usage:
//   Item channel (item_valid / item_stall) carries func, char_byte,
//   byte_valid and last. func = 0 loads pattern bytes (star, question mark,
//   backslash escape, case-insensitive literals); func = 1 streams a name.
//   Result channel (result_valid / result_stall) gives matched and
//   pattern_overflow once per name, on its last transaction.
//   A transaction moves when valid is high and stall is low.
// Timing:
//   Three register stages: input, pattern compile, match. A result is
//   registered once the name's last transaction has left the compile stage.
//   One transaction per cycle sustained while no result is held under
//   result_stall; the compile and active-set logic is combinational.
// Reset:
//   Synchronous rst clears the pattern (empty pattern, no overflow), the
//   active set and all stage valids.
// Backpressure:
//   While a result is held under result_stall the whole pipeline freezes
//   and item_stall is raised; it drops the cycle the result is taken.
module glob_wildcard_matcher
  import gwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       func,
  input  logic [7:0] char_byte,
  input  logic       byte_valid,
  input  logic       last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       matched,
  output logic       pattern_overflow
);

  logic          en;
  logic          s1_valid;
  logic          s2_valid;
  item_t         s1_item;
  item_t         s2_item;
  tok_char_vec_t token_char;
  tok_kind_vec_t token_kind;
  pat_status_t   status;
  logic          res_matched;
  logic          res_overflow;

  // Advance the pipeline unless a result is held
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      s1_valid     <= item_valid;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid && s2_item.func && s2_item.last;
    end
  end

  // Stage payloads and result
  always_ff @(posedge clk) begin
    if (en) begin
      s1_item.func       <= func;
      s1_item.char_byte  <= char_byte;
      s1_item.byte_valid <= byte_valid;
      s1_item.last       <= last;
      s2_item            <= s1_item;
      matched            <= res_matched;
      pattern_overflow   <= res_overflow;
    end
  end

  gwm_loader u_loader (
    .clk        (clk),
    .rst        (rst),
    .upd        (en && s1_valid),
    .item       (s1_item),
    .token_char (token_char),
    .token_kind (token_kind),
    .status     (status)
  );

  gwm_nfa u_nfa (
    .clk          (clk),
    .rst          (rst),
    .upd          (en && s2_valid),
    .item         (s2_item),
    .token_char   (token_char),
    .token_kind   (token_kind),
    .status       (status),
    .res_matched  (res_matched),
    .res_overflow (res_overflow)
  );

endmodule
